// File: sv/tda_pkg.sv
// ----------------------------------------------------------------------------
// tda_pkg
// Shared widths, codes and the slot table entry for the track dispatch arbiter.
// ----------------------------------------------------------------------------
package tda_pkg;

    localparam int SLOT_W = 4;
    localparam int LOAD_W = 16;

    // request kinds on the mode field
    localparam logic MODE_READY    = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    localparam logic HEADING_WEST  = 1'b0;

    typedef struct packed {
        logic              heading;
        logic              high_priority;
        logic [LOAD_W-1:0] load_time;
    } t_slot_entry;

endpackage

// File: sv/tda_ram.sv
// ----------------------------------------------------------------------------
// tda_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tda_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// File: sv/track_dispatch_arbiter_unit.sv
// ----------------------------------------------------------------------------
// track_dispatch_arbiter_unit
// Priority arbiter over a table of requester slots with heading and load
// tiebreak; grants at most one ready slot per dispatch request.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | to block  | i_in_valid/o_in_stall | mode, slot, heading, priority, load
//  out     | from block| o_out_valid/i_out_stall| granted, granted_slot, heading
//
//  A ready request does not stall the input: it writes the slot table RAM and
//  sets the slot's ready flag. A dispatch request stalls the input while it
//  scans, drains and hands over: the single RAM read port delivers one slot per
//  cycle, the drain state finishes the last compare, and the done state hands the
//  grant to the output register (waiting while that register is held by a stall).
//  Reset (synchronous, active low) clears the ready flags, the last heading
//  (west) and the control state; the RAM contents are left as they are.
//  A result waiting in the output register does not block ready requests.
//
module track_dispatch_arbiter_unit #(
    parameter int SLOTS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [tda_pkg::SLOT_W-1:0] i_slot,
    input  logic                       i_heading,
    input  logic                       i_high_priority,
    input  logic [tda_pkg::LOAD_W-1:0] i_load_time,
    // grant channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_granted,
    output logic [tda_pkg::SLOT_W-1:0] o_granted_slot,
    output logic                       o_granted_heading
);

    import tda_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int CMP_W = (SLOT_W > SW + 1) ? SLOT_W : SW + 1;
    localparam int ENT_W = $bits(t_slot_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    t_state             r_state;
    logic [SLOTS-1:0]   r_ready;
    logic               r_last_heading;

    // scan pipeline: address issued, then compare in the cycle after
    logic [SW-1:0]      r_scan_idx;
    logic               r_cmp_vld;
    logic               r_cmp_rdy;
    logic [SW-1:0]      r_cmp_idx;

    // current choice
    logic               r_found;
    logic [SW-1:0]      r_pick_idx;
    t_slot_entry        r_pick;

    // output register
    logic               r_out_valid;
    logic               r_granted;
    logic [SLOT_W-1:0]  r_granted_slot;
    logic               r_granted_heading;

    logic               in_accept;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    t_slot_entry        wr_entry;
    logic               rd_en;
    logic [ENT_W-1:0]   rd_data;
    t_slot_entry        rd_entry;
    logic               take;
    logic               out_free;

    assign in_accept = i_in_valid && (r_state == ST_IDLE);
    assign wr_en     = in_accept && (i_mode == MODE_READY)
                       && (CMP_W'(i_slot) < CMP_W'(SLOTS));
    assign wr_addr   = SW'({{SW{1'b0}}, i_slot});
    assign wr_entry  = '{heading: i_heading, high_priority: i_high_priority,
                         load_time: i_load_time};
    assign rd_en     = (r_state == ST_SCAN);
    assign rd_entry  = t_slot_entry'(rd_data);
    assign out_free  = !r_out_valid || !i_out_stall;

    tda_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (ENT_W'(wr_entry)),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan_idx),
        .o_rd_data (rd_data)
    );

    // replace the choice? first ready is taken, then high priority, then a heading other than the last, then lower load
    always_comb begin
        take = 1'b0;
        if (r_cmp_vld && r_cmp_rdy) begin
            priority if (!r_found) begin
                take = 1'b1;
            end else if (rd_entry.high_priority != r_pick.high_priority) begin
                take = rd_entry.high_priority;
            end else if (rd_entry.heading == r_pick.heading) begin
                take = (rd_entry.load_time < r_pick.load_time);
            end else begin
                take = (r_pick.heading == r_last_heading);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_ready        <= '0;
            r_last_heading <= HEADING_WEST;
            r_cmp_vld      <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // in ST_DONE the output register is reloaded instead
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (take) begin
                r_found    <= 1'b1;
                r_pick_idx <= r_cmp_idx;
                r_pick     <= rd_entry;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (wr_en) begin
                        r_ready[wr_addr] <= 1'b1;
                    end
                    if (in_accept && (i_mode == MODE_DISPATCH)) begin
                        r_scan_idx <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_found    <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_scan_idx;
                    r_cmp_rdy <= r_ready[r_scan_idx];
                    if (r_scan_idx == SW'(SLOTS - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_granted   <= r_found;
                        if (r_found) begin
                            r_granted_slot    <= SLOT_W'({{SLOT_W{1'b0}}, r_pick_idx});
                            r_granted_heading <= r_pick.heading;
                            r_ready[r_pick_idx] <= 1'b0;
                            r_last_heading    <= r_pick.heading;
                        end else begin
                            r_granted_slot    <= '0;
                            r_granted_heading <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_granted         = r_granted;
    assign o_granted_slot    = r_granted_slot;
    assign o_granted_heading = r_granted_heading;

endmodule
